/* rtl/hbk_pkg.sv */
`timescale 1ns / 1ps

package hbk_pkg;

  // Field widths fixed by the channel and register definitions.
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 1'b1;

  // Operation codes carried by the input channel.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_TOP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Status codes returned with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

endpackage

/* rtl/hbk_ifs.sv */
`timescale 1ns / 1ps

// Command channel: operation code and key.
interface hbk_in_if #(
  parameter int KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic [hbk_pkg::OP_W-1:0]    op;
  logic [KEY_WIDTH-1:0]        key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// Result channel: status, root key and entry count.
interface hbk_out_if #(
  parameter int KEY_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic [hbk_pkg::STATUS_W-1:0]   status;
  logic [KEY_WIDTH-1:0]           top_key;
  logic [hbk_pkg::COUNT_W-1:0]    count;

  modport source (output valid, output status, output top_key, output count, input ready);
  modport sink   (input valid, input status, input top_key, input count, output ready);
endinterface

/* rtl/hbk_rank.sv */
`timescale 1ns / 1ps

// Shared key comparator: high when key a belongs further from the root than key b.
module hbk_rank #(
  parameter int KEY_WIDTH = 32
) (
  input  logic [KEY_WIDTH-1:0] a,
  input  logic [KEY_WIDTH-1:0] b,
  input  logic                 descending,
  output logic                 after
);

  // A max-heap keeps smaller keys lower, a min-heap keeps larger keys lower.
  always_comb begin
    if (descending) begin
      after = (a < b);
    end else begin
      after = (a > b);
    end
  end

endmodule

/* rtl/hbk_ctrl.sv */
`timescale 1ns / 1ps

// Heap sequencer: key store, root copy, sift up and sift down walks, result register.
module hbk_ctrl #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [CNT_W-1:0]               eff_cap,
  input  logic                           descending,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hbk_pkg::OP_W-1:0]       in_op,
  input  logic [KEY_WIDTH-1:0]           in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hbk_pkg::STATUS_W-1:0]   out_status,
  output logic [KEY_WIDTH-1:0]           out_top_key,
  output logic [hbk_pkg::COUNT_W-1:0]    out_count
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FULL,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            n_r, n_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic [IDX_W-1:0]            par_r, par_nxt;
  logic [IDX_W-1:0]            cidx_r, cidx_nxt;
  logic [IDX_W-1:0]            bidx_r, bidx_nxt;
  logic                        has_r, has_nxt;
  logic [KEY_WIDTH-1:0]        v_r, v_nxt;
  logic [KEY_WIDTH-1:0]        best_r, best_nxt;
  logic [KEY_WIDTH-1:0]        root_r, root_nxt;
  hbk_pkg::status_t            status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  hbk_pkg::status_t            out_status_r, out_status_nxt;
  logic [KEY_WIDTH-1:0]        out_top_r, out_top_nxt;
  logic [hbk_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // Key store with one write port and two registered read ports.
  logic [KEY_WIDTH-1:0] heap_mem [DEPTH];
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [KEY_WIDTH-1:0] mem_wd;
  logic [IDX_W-1:0]     mem_ra;
  logic [IDX_W-1:0]     mem_rb;
  logic [KEY_WIDTH-1:0] rd_a;
  logic [KEY_WIDTH-1:0] rd_b;

  // Shared comparator operands.
  logic [KEY_WIDTH-1:0] cmp_a;
  logic [KEY_WIDTH-1:0] cmp_b;
  logic                 cmp_after;

  logic [CNT_W-1:0]         child;
  logic [CNT_W-1:0]         right;
  logic [IDX_W-1:0]         parent;
  logic [CNT_W+6:0]         cnt_wide;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_wa] <= mem_wd;
    end
    rd_a <= heap_mem[mem_ra];
    rd_b <= heap_mem[mem_rb];
  end

  hbk_rank #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_rank (
    .a          (cmp_a),
    .b          (cmp_b),
    .descending (descending),
    .after      (cmp_after)
  );

  // Operand selection for the comparator in each step.
  always_comb begin
    case (state_r)
      S_FULL: begin
        cmp_a = v_r;
        cmp_b = root_r;
      end
      S_UP_CMP: begin
        cmp_a = rd_a;
        cmp_b = v_r;
      end
      S_DN_SEL: begin
        cmp_a = rd_a;
        cmp_b = rd_b;
      end
      default: begin
        cmp_a = v_r;
        cmp_b = best_r;
      end
    endcase
  end

  // Tree addresses around the current position.
  assign child    = {pos_r, 1'b1};
  assign right    = child + CNT_W'(1);
  assign parent   = (pos_r - IDX_W'(1)) >> 1;
  assign cnt_wide = {7'd0, cnt_r};

  // Sequencer next-state logic.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    pos_nxt        = pos_r;
    par_nxt        = par_r;
    cidx_nxt       = cidx_r;
    bidx_nxt       = bidx_r;
    has_nxt        = has_r;
    v_nxt          = v_r;
    best_nxt       = best_r;
    status_nxt     = status_r;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_count_nxt  = out_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = v_r;
    mem_ra         = par_r;
    mem_rb         = par_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          v_nxt      = in_key;
          status_nxt = hbk_pkg::ST_OK;
          case (hbk_pkg::op_t'(in_op))
            hbk_pkg::OP_PUSH: begin
              if (cnt_r >= eff_cap) begin
                state_nxt = S_FULL;
              end else begin
                pos_nxt   = cnt_r[IDX_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            hbk_pkg::OP_POP: begin
              if (cnt_r == '0) begin
                status_nxt = hbk_pkg::ST_EMPTY;
                state_nxt  = S_FIN;
              end else begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                state_nxt = (cnt_r == CNT_W'(1)) ? S_FIN : S_POP_RD;
              end
            end
            hbk_pkg::OP_TOP: begin
              if (cnt_r == '0) begin
                status_nxt = hbk_pkg::ST_EMPTY;
              end
              state_nxt = S_FIN;
            end
            default: begin
              cnt_nxt   = '0;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      // Full heap: replace the root only when the key ranks after it.
      S_FULL: begin
        if (cmp_after) begin
          pos_nxt   = '0;
          n_nxt     = cnt_r;
          state_nxt = S_DN_RD;
        end else begin
          status_nxt = hbk_pkg::ST_DROPPED;
          state_nxt  = S_FIN;
        end
      end

      // Pop: fetch the last entry, then sift it down from the root.
      S_POP_RD: begin
        mem_ra    = cnt_r[IDX_W-1:0];
        state_nxt = S_POP_LD;
      end
      S_POP_LD: begin
        v_nxt     = rd_a;
        pos_nxt   = '0;
        n_nxt     = cnt_r;
        state_nxt = S_DN_RD;
      end

      // Sift up: read the parent, then move it down or settle the key.
      S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          mem_ra    = parent;
          par_nxt   = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_after) begin
          mem_wd    = rd_a;
          pos_nxt   = par_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Sift down: read both children, pick the one nearer the root, compare.
      S_DN_RD: begin
        if (child >= n_r) begin
          mem_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          mem_ra    = child[IDX_W-1:0];
          has_nxt   = (right < n_r);
          mem_rb    = (right < n_r) ? right[IDX_W-1:0] : child[IDX_W-1:0];
          cidx_nxt  = child[IDX_W-1:0];
          state_nxt = S_DN_SEL;
        end
      end
      S_DN_SEL: begin
        if (has_r && cmp_after) begin
          best_nxt = rd_b;
          bidx_nxt = cidx_r + IDX_W'(1);
        end else begin
          best_nxt = rd_a;
          bidx_nxt = cidx_r;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (cmp_after) begin
          mem_wd    = best_r;
          pos_nxt   = bidx_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      // Load the result register once it is free.
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_top_nxt    = (cnt_r != '0) ? root_r : '0;
          out_count_nxt  = cnt_wide[6:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The root is kept in a register so it can be reported and compared at once.
  assign root_nxt = (mem_we && (mem_wa == '0)) ? mem_wd : root_r;

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    pos_r        <= pos_nxt;
    par_r        <= par_nxt;
    cidx_r       <= cidx_nxt;
    bidx_r       <= bidx_nxt;
    has_r        <= has_nxt;
    v_r          <= v_nxt;
    best_r       <= best_nxt;
    root_r       <= root_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_count_r  <= out_count_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_top_key = out_top_r;
  assign out_count   = out_count_r;

endmodule

/* rtl/bounded_top_k_binary_heap.sv */
`timescale 1ns / 1ps
// Top, clear, a pop of an empty or one-entry heap and a dropped push need no walk of the tree.
// A push into a heap that is not full sifts the key up, reading and comparing one parent per level climbed.
// Pop and a replacing push sift the key down from the root, reading both children at each level descended.
// The walks are bounded by the height of the heap; a result that waits on the output stalls the next item.
// One item is in flight at a time; the single comparator and the store's registered reads set the pace.
// Reset (synchronous, active low) empties the heap, clears the result valid flag and loads defaults.
module bounded_top_k_binary_heap #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hbk_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hbk_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  hbk_in_if.sink                           in_ch,
  hbk_out_if.source                        out_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int CAP_RESET_I = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [hbk_pkg::CAP_W-1:0] CAP_RESET = hbk_pkg::CAP_W'(CAP_RESET_I);
  localparam logic [CNT_W+hbk_pkg::CAP_W-1:0] DEPTH_EXT = (CNT_W + hbk_pkg::CAP_W)'(DEPTH);

  logic [hbk_pkg::CAP_W-1:0]         cap_r;
  logic                              desc_r;
  logic [CNT_W+hbk_pkg::CAP_W-1:0]   cap_ext;
  logic [CNT_W-1:0]                  eff_cap;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      desc_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        hbk_pkg::CFG_CAPACITY: cap_r  <= cfg_wdata[hbk_pkg::CAP_W-1:0];
        hbk_pkg::CFG_ORDER:    desc_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Capacity in use: zero counts as one, anything above the store size as the store size.
  assign cap_ext = {{CNT_W{1'b0}}, cap_r};
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > DEPTH_EXT) begin
      eff_cap = DEPTH_EXT[CNT_W-1:0];
    end else begin
      eff_cap = cap_ext[CNT_W-1:0];
    end
  end

  hbk_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .eff_cap     (eff_cap),
    .descending  (desc_r),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_op       (in_ch.op),
    .in_key      (in_ch.key),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_top_key (out_ch.top_key),
    .out_count   (out_ch.count)
  );

endmodule
